[sv/udpsd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udpsd_pkg
// shared types, codes and sizes of the udp socket demux table
// ----------------------------------------------------------------------------
package udpsd_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int ADDR_W        = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int PROBES        = 10;
    localparam int PROBES_PASS   = 5;

    localparam logic [31:0] ANY_ADDR  = 32'hFFFF_FFFF;
    localparam logic [31:0] ZERO_ADDR = 32'h0000_0000;
    localparam logic [15:0] ZERO_PORT = 16'h0000;

    localparam logic [1:0] KIND_MAP    = 2'd0;
    localparam logic [1:0] KIND_UNMAP  = 2'd1;
    localparam logic [1:0] KIND_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_DONE     = 2'd0;
    localparam logic [1:0] STATUS_OVERRIDE = 2'd1;
    localparam logic [1:0] STATUS_FULL     = 2'd2;

    typedef logic [47:0] t_half;

    typedef struct packed {
        t_half       first_half;
        t_half       second_half;
        logic [15:0] handle;
    } t_entry;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } t_state;

    function automatic t_half make_half(input logic [31:0] ip, input logic [15:0] port);
        return {ip, port};
    endfunction

endpackage
`default_nettype wire

[sv/udp_socket_demux_table.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// udp_socket_demux_table
// socket flow table with map, unmap and prioritized wildcard lookup
// ----------------------------------------------------------------------------
// Each transaction is accepted in S_IDLE and the table memory, which has one
// read port, is swept one entry per cycle in S_SCAN. The read is registered,
// so the last entry is compared in S_DRAIN; S_COMMIT then does the write-back
// and also loads the result. The input is ready again only once the block is
// back in S_IDLE after the write-back, so a new transaction is accepted only
// when the last one is through. One transaction is in the table at a time; a
// finished result waits in the output register while the next transaction is
// accepted and swept, and a result still waiting there at write-back holds
// the write-back until it is taken. Lookups compare every entry against all
// ten probe keys in the same cycle and keep the lowest-numbered probe that
// hits. Map inserts at the lowest free slot.
// ----------------------------------------------------------------------------
module udp_socket_demux_table (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_kind,
    input  wire logic [31:0] i_first_ip,
    input  wire logic [15:0] i_first_port,
    input  wire logic [31:0] i_second_ip,
    input  wire logic [15:0] i_second_port,
    input  wire logic [15:0] i_socket_handle,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_hit,
    output logic [15:0]      o_found_handle,
    output logic [3:0]       o_match_probe,
    output logic [1:0]       o_status
);
    import udpsd_pkg::*;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_ENTRIES - 1);

    t_state r_state;
    t_state n_state;

    // captured transaction
    logic [1:0]  r_kind;
    logic [31:0] r_fip;
    logic [15:0] r_fport;
    logic [31:0] r_sip;
    logic [15:0] r_sport;
    logic [15:0] r_handle;

    // sweep
    logic [ADDR_W-1:0] r_addr;
    logic [ADDR_W-1:0] r_rd_idx;
    logic              r_rd_vld;
    t_entry            r_rd_data;
    t_entry            mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_valid;

    // best match and first free slot
    logic              r_found;
    logic [3:0]        r_probe;
    logic [ADDR_W-1:0] r_slot;
    logic [15:0]       r_fhandle;
    logic              r_free_found;
    logic [ADDR_W-1:0] r_free_slot;

    // output register
    logic        r_out_valid;
    logic        r_hit;
    logic [15:0] r_found_handle;
    logic [3:0]  r_match_probe;
    logic [1:0]  r_status;
    logic        n_hit;
    logic [15:0] n_found_handle;
    logic [3:0]  n_match_probe;
    logic [1:0]  n_status;

    logic              in_acc;
    logic              commit_go;
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    t_entry            mem_wdata;
    logic              set_valid;
    logic              clr_valid;

    // probe compare
    t_half             key_a;
    t_half             key_b;
    t_half             probe_a [PROBES];
    t_half             probe_b [PROBES];
    logic [PROBES-1:0] hit_vec;
    logic              ent_valid;
    logic              cmp_hit;
    logic [3:0]        cmp_probe;
    logic [31:0]       src_ip;

    assign in_acc = i_in_valid && o_in_ready;
    assign key_a  = make_half(r_fip, r_fport);
    assign key_b  = make_half(r_sip, r_sport);

    always_comb begin
        for (int q = 0; q < 2; q++) begin
            src_ip = (q == 0) ? r_fip : ZERO_ADDR;
            probe_a[q*PROBES_PASS+0] = make_half(r_sip, r_sport);
            probe_b[q*PROBES_PASS+0] = make_half(src_ip, r_fport);
            probe_a[q*PROBES_PASS+1] = make_half(src_ip, r_fport);
            probe_b[q*PROBES_PASS+1] = make_half(ANY_ADDR, r_sport);
            probe_a[q*PROBES_PASS+2] = make_half(src_ip, ZERO_PORT);
            probe_b[q*PROBES_PASS+2] = make_half(ANY_ADDR, r_sport);
            probe_a[q*PROBES_PASS+3] = make_half(ZERO_ADDR, r_fport);
            probe_b[q*PROBES_PASS+3] = make_half(ANY_ADDR, r_sport);
            probe_a[q*PROBES_PASS+4] = make_half(ZERO_ADDR, ZERO_PORT);
            probe_b[q*PROBES_PASS+4] = make_half(ANY_ADDR, r_sport);
        end
    end

    always_comb begin
        ent_valid = r_valid[r_rd_idx];
        hit_vec   = '0;
        if (r_kind == KIND_LOOKUP) begin
            for (int p = 0; p < PROBES; p++) begin
                hit_vec[p] = ent_valid && (r_rd_data.first_half == probe_a[p])
                             && (r_rd_data.second_half == probe_b[p]);
            end
        end else if (r_kind == KIND_MAP || r_kind == KIND_UNMAP) begin
            hit_vec[0] = ent_valid && (r_rd_data.first_half == key_a)
                         && (r_rd_data.second_half == key_b);
        end
        cmp_hit   = |hit_vec;
        cmp_probe = '0;
        for (int p = PROBES - 1; p >= 0; p--) begin
            if (hit_vec[p]) begin
                cmp_probe = 4'(p);
            end
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc) n_state = S_SCAN;
            S_SCAN:   if (r_addr == LAST_ADDR) n_state = S_DRAIN;
            S_DRAIN:  n_state = S_COMMIT;
            S_COMMIT: if (commit_go) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_in_ready     = (r_state == S_IDLE);
        commit_go      = (r_state == S_COMMIT) && (!r_out_valid || i_out_ready);
        mem_we         = 1'b0;
        mem_waddr      = r_slot;
        mem_wdata      = '{first_half: key_a, second_half: key_b, handle: r_handle};
        set_valid      = 1'b0;
        clr_valid      = 1'b0;
        n_hit          = 1'b0;
        n_found_handle = '0;
        n_match_probe  = '0;
        n_status       = STATUS_DONE;
        if (commit_go) begin
            unique case (r_kind)
                KIND_MAP: begin
                    if (r_found) begin
                        mem_we   = 1'b1;
                        n_status = STATUS_OVERRIDE;
                    end else if (r_free_found) begin
                        mem_we    = 1'b1;
                        mem_waddr = r_free_slot;
                        set_valid = 1'b1;
                    end else begin
                        n_status = STATUS_FULL;
                    end
                end
                KIND_UNMAP: begin
                    if (r_found) begin
                        clr_valid      = 1'b1;
                        n_hit          = 1'b1;
                        n_found_handle = r_fhandle;
                    end
                end
                KIND_LOOKUP: begin
                    if (r_found) begin
                        n_hit          = 1'b1;
                        n_found_handle = r_fhandle;
                        n_match_probe  = r_probe;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // table memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rd_data <= mem[r_addr];
        r_rd_idx  <= r_addr;
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_kind   <= i_kind;
            r_fip    <= i_first_ip;
            r_fport  <= i_first_port;
            r_sip    <= i_second_ip;
            r_sport  <= i_second_port;
            r_handle <= i_socket_handle;
        end
        if (r_rd_vld && cmp_hit && (!r_found || cmp_probe < r_probe)) begin
            r_probe   <= cmp_probe;
            r_slot    <= r_rd_idx;
            r_fhandle <= r_rd_data.handle;
        end
        if (r_rd_vld && !ent_valid && !r_free_found) begin
            r_free_slot <= r_rd_idx;
        end
        if (commit_go) begin
            r_hit          <= n_hit;
            r_found_handle <= n_found_handle;
            r_match_probe  <= n_match_probe;
            r_status       <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_addr       <= '0;
            r_rd_vld     <= 1'b0;
            r_valid      <= '0;
            r_found      <= 1'b0;
            r_free_found <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_rd_vld <= (r_state == S_SCAN);
            if (in_acc) begin
                r_addr       <= '0;
                r_found      <= 1'b0;
                r_free_found <= 1'b0;
            end else begin
                if (r_state == S_SCAN) begin
                    r_addr <= r_addr + 1'b1;
                end
                if (r_rd_vld && cmp_hit) begin
                    r_found <= 1'b1;
                end
                if (r_rd_vld && !ent_valid) begin
                    r_free_found <= 1'b1;
                end
            end
            if (set_valid) begin
                r_valid[r_free_slot] <= 1'b1;
            end
            if (clr_valid) begin
                r_valid[r_slot] <= 1'b0;
            end
            if (commit_go) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_hit          = r_hit;
    assign o_found_handle = r_found_handle;
    assign o_match_probe  = r_match_probe;
    assign o_status       = r_status;

    // each sweep starts at the first entry
    a_sweep_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> (r_state == S_SCAN) && (r_addr == '0))
        else $error("sweep did not start at entry zero");

    // a lookup never changes the table
    a_lookup_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (commit_go && r_kind == KIND_LOOKUP) |=> $stable(r_valid))
        else $error("lookup modified the valid bits");

    // a new insert occupies exactly one more slot
    a_insert_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        set_valid |=> $countones(r_valid) == $past($countones(r_valid)) + 1)
        else $error("insert did not add one entry");

    // an unmap hit frees exactly one slot
    a_erase_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        clr_valid |=> $countones(r_valid) + 1 == $past($countones(r_valid)))
        else $error("unmap did not free one entry");

    // a miss reports probe zero and handle zero
    a_miss_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_hit) |-> (o_match_probe == '0) && (o_found_handle == '0))
        else $error("miss carries a probe index or handle");

endmodule
`default_nettype wire

[dv/tb_udp_socket_demux_table.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_udp_socket_demux_table
// self-checking bench for the socket flow table: a short directed walk over
// map, unmap and every lookup priority, then random traffic built around a
// pool of datagrams so that wildcard entries hit, the table fills and drains,
// with random gaps on the request side and random stalls on the result side
// ----------------------------------------------------------------------------
module tb_udp_socket_demux_table;
    import udpsd_pkg::*;

    localparam logic [1:0]  KIND_NONE = 2'd3;
    localparam int          RANDOM_ITEMS = 800;
    localparam int          POOL = 16;

    localparam logic [31:0] SRC_A  = 32'hC0A8_0001;
    localparam logic [15:0] SRC_P  = 16'd1234;
    localparam logic [31:0] DST_A  = 32'h0A00_0001;
    localparam logic [15:0] DST_P  = 16'd53;
    localparam logic [31:0] SRC2_A = 32'hFFFF_FFFF;
    localparam logic [15:0] SRC2_P = 16'hFFFF;
    localparam logic [31:0] DST2_A = 32'h8000_0001;
    localparam logic [15:0] DST2_P = 16'hFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] first_ip;
        logic [15:0] first_port;
        logic [31:0] second_ip;
        logic [15:0] second_port;
        logic [15:0] handle;
    } t_xact;

    typedef struct packed {
        logic        hit;
        logic [15:0] found_handle;
        logic [3:0]  match_probe;
        logic [1:0]  status;
    } t_outcome;

    typedef struct packed {
        t_xact    x;
        logic     typed;
        t_outcome want;
    } t_step;

    localparam t_outcome ZERO_RESULT     = '0;
    localparam t_outcome OVERRIDE_RESULT = '{1'b0, 16'h0, 4'd0, STATUS_OVERRIDE};

    t_step plan [0:24] = '{
        '{'{KIND_LOOKUP, SRC_A, SRC_P, DST_A, DST_P, 16'h0}, 1'b1, ZERO_RESULT},
        '{'{KIND_UNMAP, SRC_A, SRC_P, DST_A, DST_P, 16'h0}, 1'b1, ZERO_RESULT},
        '{'{KIND_NONE, 32'hFFFF_FFFF, 16'hFFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF},
          1'b1, ZERO_RESULT},
        '{'{KIND_MAP, ZERO_ADDR, ZERO_PORT, ANY_ADDR, DST_P, 16'h0}, 1'b1, ZERO_RESULT},
        '{'{KIND_LOOKUP, SRC_A, SRC_P, DST_A, DST_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_MAP, ZERO_ADDR, SRC_P, ANY_ADDR, DST_P, 16'h3}, 1'b1, ZERO_RESULT},
        '{'{KIND_LOOKUP, SRC_A, SRC_P, DST_A, DST_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_MAP, SRC_A, ZERO_PORT, ANY_ADDR, DST_P, 16'h2}, 1'b1, ZERO_RESULT},
        '{'{KIND_LOOKUP, SRC_A, SRC_P, DST_A, DST_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_MAP, SRC_A, SRC_P, ANY_ADDR, DST_P, 16'h1}, 1'b1, ZERO_RESULT},
        '{'{KIND_LOOKUP, SRC_A, SRC_P, DST_A, DST_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_MAP, DST_A, DST_P, SRC_A, SRC_P, 16'hFFFF}, 1'b1, ZERO_RESULT},
        '{'{KIND_LOOKUP, SRC_A, SRC_P, DST_A, DST_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_MAP, DST_A, DST_P, SRC_A, SRC_P, 16'hABCD}, 1'b1, OVERRIDE_RESULT},
        '{'{KIND_UNMAP, DST_A, DST_P, SRC_A, SRC_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_LOOKUP, SRC_A, SRC_P, DST_A, DST_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_MAP, DST2_A, DST2_P, ZERO_ADDR, SRC2_P, 16'h5}, 1'b1, ZERO_RESULT},
        '{'{KIND_LOOKUP, SRC2_A, SRC2_P, DST2_A, DST2_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_MAP, DST2_A, DST2_P, SRC2_A, SRC2_P, 16'hFFFF}, 1'b1, ZERO_RESULT},
        '{'{KIND_LOOKUP, SRC2_A, SRC2_P, DST2_A, DST2_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_UNMAP, DST2_A, DST2_P, SRC2_A, SRC2_P, 16'h0}, 1'b0, ZERO_RESULT},
        '{'{KIND_MAP, ZERO_ADDR, ZERO_PORT, ZERO_ADDR, ZERO_PORT, 16'h0}, 1'b1, ZERO_RESULT},
        '{'{KIND_LOOKUP, ZERO_ADDR, ZERO_PORT, ZERO_ADDR, ZERO_PORT, 16'h0}, 1'b0,
          ZERO_RESULT},
        '{'{KIND_NONE, ZERO_ADDR, ZERO_PORT, ZERO_ADDR, ZERO_PORT, 16'h0}, 1'b1, ZERO_RESULT},
        '{'{KIND_UNMAP, ZERO_ADDR, ZERO_PORT, ANY_ADDR, DST_P, 16'h0}, 1'b0, ZERO_RESULT}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_first_ip = '0;
    logic [15:0] i_first_port = '0;
    logic [31:0] i_second_ip = '0;
    logic [15:0] i_second_port = '0;
    logic [15:0] i_socket_handle = '0;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic        o_hit;
    logic [15:0] o_found_handle;
    logic [3:0]  o_match_probe;
    logic [1:0]  o_status;

    logic        sock_valid [TABLE_ENTRIES];
    t_half       sock_first [TABLE_ENTRIES];
    t_half       sock_second [TABLE_ENTRIES];
    logic [15:0] sock_handle [TABLE_ENTRIES];

    // ring of expected results, far deeper than the transactions in flight
    t_outcome    pending_outcomes [16];
    int          exp_wr = 0;
    int          exp_rd = 0;
    int          mismatches = 0;
    int          sent_count = 0;
    int          taken_count = 0;

    always #1 i_clk = ~i_clk;

    udp_socket_demux_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_kind          (i_kind),
        .i_first_ip      (i_first_ip),
        .i_first_port    (i_first_port),
        .i_second_ip     (i_second_ip),
        .i_second_port   (i_second_port),
        .i_socket_handle (i_socket_handle),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_hit           (o_hit),
        .o_found_handle  (o_found_handle),
        .o_match_probe   (o_match_probe),
        .o_status        (o_status)
    );

    // probe keys of a received datagram, in priority order
    function automatic void probe_key(input t_xact x, input int p,
                                      output t_half ka, output t_half kb);
        logic [31:0] src;
        src = (p < PROBES_PASS) ? x.first_ip : ZERO_ADDR;
        case (p % PROBES_PASS)
            0: begin
                ka = {x.second_ip, x.second_port};
                kb = {src, x.first_port};
            end
            1: begin
                ka = {src, x.first_port};
                kb = {ANY_ADDR, x.second_port};
            end
            2: begin
                ka = {src, ZERO_PORT};
                kb = {ANY_ADDR, x.second_port};
            end
            3: begin
                ka = {ZERO_ADDR, x.first_port};
                kb = {ANY_ADDR, x.second_port};
            end
            default: begin
                ka = {ZERO_ADDR, ZERO_PORT};
                kb = {ANY_ADDR, x.second_port};
            end
        endcase
    endfunction

    function automatic int find_entry(t_half a, t_half b);
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (sock_valid[i] && sock_first[i] == a && sock_second[i] == b) begin
                return i;
            end
        end
        return -1;
    endfunction

    // applies one transaction to the shadow table and returns its result
    function automatic t_outcome table_apply(t_xact x);
        t_outcome o;
        t_half    a;
        t_half    b;
        t_half    ka;
        t_half    kb;
        int       slot;
        o = '0;
        a = {x.first_ip, x.first_port};
        b = {x.second_ip, x.second_port};
        case (x.kind)
            KIND_MAP: begin
                slot = find_entry(a, b);
                if (slot >= 0) begin
                    sock_handle[slot] = x.handle;
                    o.status = STATUS_OVERRIDE;
                end else begin
                    o.status = STATUS_FULL;
                    for (int i = 0; i < TABLE_ENTRIES; i++) begin
                        if (!sock_valid[i]) begin
                            sock_valid[i]  = 1'b1;
                            sock_first[i]  = a;
                            sock_second[i] = b;
                            sock_handle[i] = x.handle;
                            o.status = STATUS_DONE;
                            break;
                        end
                    end
                end
            end
            KIND_UNMAP: begin
                slot = find_entry(a, b);
                if (slot >= 0) begin
                    o.hit = 1'b1;
                    o.found_handle = sock_handle[slot];
                    sock_valid[slot] = 1'b0;
                end
            end
            KIND_LOOKUP: begin
                for (int p = 0; p < PROBES; p++) begin
                    probe_key(x, p, ka, kb);
                    slot = find_entry(ka, kb);
                    if (slot >= 0) begin
                        o.hit = 1'b1;
                        o.found_handle = sock_handle[slot];
                        o.match_probe = p[3:0];
                        break;
                    end
                end
            end
            default: begin
            end
        endcase
        return o;
    endfunction

    task automatic send_xact(input t_xact x, input logic typed, input t_outcome want);
        int       gap;
        t_outcome predicted;
        gap = ((sent_count % 64) >= 48) ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        {i_kind, i_first_ip, i_first_port, i_second_ip, i_second_port, i_socket_handle} <= x;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = table_apply(x);
        pending_outcomes[exp_wr[3:0]] = typed ? want : predicted;
        exp_wr++;
        sent_count++;
    endtask

    // result side: random stalls once a result is offered
    initial begin
        int stall;
        forever begin
            stall = ((taken_count % 80) < 16) ? 0 : $urandom_range(0, 16);
            if (stall == 0) begin
                i_out_ready <= 1'b1;
                do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
            end else begin
                i_out_ready <= 1'b0;
                do @(posedge i_clk); while (!(i_rst_n && o_out_valid));
                repeat (stall - 1) @(posedge i_clk);
                i_out_ready <= 1'b1;
                @(posedge i_clk);
            end
            taken_count++;
        end
    end

    always @(posedge i_clk) begin
        t_outcome exp_o;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (exp_rd == exp_wr) begin
                $error("result transaction with nothing expected");
                mismatches++;
            end else begin
                exp_o = pending_outcomes[exp_rd[3:0]];
                exp_rd++;
                if (o_hit !== exp_o.hit) begin
                    $error("hit: expected %0h, got %0h", exp_o.hit, o_hit);
                    mismatches++;
                end
                if (o_found_handle !== exp_o.found_handle) begin
                    $error("found_handle: expected %0h, got %0h",
                           exp_o.found_handle, o_found_handle);
                    mismatches++;
                end
                if (o_match_probe !== exp_o.match_probe) begin
                    $error("match_probe: expected %0d, got %0d",
                           exp_o.match_probe, o_match_probe);
                    mismatches++;
                end
                if (o_status !== exp_o.status) begin
                    $error("status: expected %0d, got %0d", exp_o.status, o_status);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        #1_000_000;
        $display("tb_udp_socket_demux_table: done, errors");
        $finish;
    end

    initial begin
        t_xact dgrams [POOL];
        t_xact x;
        t_half ka;
        t_half kb;
        int    counted;
        int    r;
        int    fill;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            sock_valid[i] = 1'b0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[i]) begin
            send_xact(plan[i].x, plan[i].typed, plan[i].want);
        end

        // datagram pool, some sharing ports so wildcard entries collide
        for (int t = 0; t < POOL; t++) begin
            dgrams[t] = {KIND_LOOKUP, 32'($urandom), 16'($urandom), 32'($urandom),
                         16'($urandom), 16'h0};
            if (t % 4 == 0) dgrams[t].first_port = 16'hFFFF;
            if (t % 5 == 1) dgrams[t].second_port = ZERO_PORT;
            if (t % 3 == 2) dgrams[t].second_port = dgrams[0].second_port;
            if (t == POOL - 1) dgrams[t].first_ip = ZERO_ADDR;
        end

        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            fill = ((counted / 200) % 2) == 0;
            r = $urandom_range(0, 99);
            x = dgrams[$urandom_range(0, POOL - 1)];
            if (r >= 97) begin
                x = {KIND_NONE, 32'($urandom), 16'($urandom), 32'($urandom),
                     16'($urandom), 16'($urandom)};
            end else if (r < (fill ? 75 : 25) || r < (fill ? 80 : 60)) begin
                probe_key(x, $urandom_range(0, PROBES - 1), ka, kb);
                x.kind = (r < (fill ? 75 : 25)) ? KIND_MAP : KIND_UNMAP;
                {x.first_ip, x.first_port} = ka;
                {x.second_ip, x.second_port} = kb;
                x.handle = 16'($urandom);
                if ($urandom_range(0, 9) == 0) begin
                    {x.first_ip, x.first_port, x.second_ip, x.second_port} =
                        {32'($urandom), 16'($urandom), 32'($urandom), 16'($urandom)};
                end
            end else begin
                case ($urandom_range(0, 9))
                    0: x.first_ip = ZERO_ADDR;
                    1: x.first_ip = 32'($urandom);
                    2: {x.first_ip, x.first_port, x.second_ip, x.second_port} =
                           {32'($urandom), 16'($urandom), 32'($urandom), 16'($urandom)};
                    default: begin
                    end
                endcase
                x.handle = 16'($urandom);
            end
            send_xact(x, 1'b0, ZERO_RESULT);
            if (x.kind != KIND_NONE) counted++;
        end
        i_in_valid <= 1'b0;

        while (exp_rd != exp_wr) @(posedge i_clk);
        repeat (TABLE_ENTRIES + 16) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_udp_socket_demux_table: done, clean");
        end else begin
            $display("tb_udp_socket_demux_table: done, errors");
        end
        $finish;
    end

endmodule
